### sv/blq_pkg.sv
// Package with sizes, reset values and codes shared by the battery level qualifier.
`timescale 1ns / 1ps

package blq_pkg;

  // Measurement size: samples in the stability phase and in the averaging phase.
  // The average is taken by a shift, so this must be a power of two.
  localparam int SAMPLES_PER_PHASE = 8;
  localparam int AVG_SHIFT         = $clog2(SAMPLES_PER_PHASE);
  localparam int INDEX_W           = $clog2(2 * SAMPLES_PER_PHASE);
  localparam int SUM_W             = $clog2(SAMPLES_PER_PHASE * 4095 + 1);

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int RATIO_W  = 12;
  localparam int LIMIT_W  = 8;
  localparam int CELL_W   = 14;
  localparam int PROD_W   = SAMPLE_W + RATIO_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [SAMPLE_W-1:0] ADC_MAX  = '1;
  localparam logic [CELL_W-1:0]   CELL_MAX = '1;

  // Register reset values.
  localparam logic [RATIO_W-1:0] RATIO_RESET    = 12'd1254;
  localparam logic [LIMIT_W-1:0] SPREAD_RESET   = 8'd40;
  localparam logic [CELL_W-1:0]  FLOOR_RESET    = 14'd2500;
  localparam logic [CELL_W-1:0]  LOW_RESET      = 14'd3500;
  localparam logic [CELL_W-1:0]  CRITICAL_RESET = 14'd3350;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVIDER_RATIO = 3'd0,
    CFG_SPREAD_LIMIT  = 3'd1,
    CFG_FLOOR         = 3'd2,
    CFG_LOW           = 3'd3,
    CFG_CRITICAL      = 3'd4
  } cfg_index_t;

  // Battery level codes.
  typedef enum logic [1:0] {
    LEVEL_NORMAL   = 2'd0,
    LEVEL_LOW      = 2'd1,
    LEVEL_CRITICAL = 2'd2
  } level_t;

endpackage

### sv/battery_level_qualifier.sv
// Battery level qualifier: sample accumulation, scaling and level classification.
`timescale 1ns / 1ps

// Takes one ADC sample per cycle while in_ready is high. A measurement is
// 2*SAMPLES_PER_PHASE samples (16 by default): the first half tracks min and
// max for a stability check, the second half is summed and averaged. A sample
// with restart set begins a new measurement. One result follows each completed
// measurement, through a stage that registers the average and stability flag
// and an output stage that holds the scaled voltage (one 12x12 multiply) and
// level. Input is accepted every cycle while the output stage can drain; a
// waiting result only stalls input when both stages are full. Configuration
// writes are always accepted; indexes past the last register are ignored.
module battery_level_qualifier (
  input  logic                          clk,
  input  logic                          rst,
  // Sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [blq_pkg::SAMPLE_W-1:0]  sample_mv,
  input  logic                          restart,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blq_pkg::CELL_W-1:0]    cell_mv,
  output logic                          valid_res,
  output logic [1:0]                    level,
  // Configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blq_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [blq_pkg::RATIO_W-1:0] divider_ratio_q8;
  logic [blq_pkg::LIMIT_W-1:0] spread_limit_mv;
  logic [blq_pkg::CELL_W-1:0]  floor_mv;
  logic [blq_pkg::CELL_W-1:0]  low_mv;
  logic [blq_pkg::CELL_W-1:0]  critical_mv;

  // Measurement state.
  logic [blq_pkg::INDEX_W-1:0]  sample_index;
  logic [blq_pkg::SAMPLE_W-1:0] min_seen;
  logic [blq_pkg::SAMPLE_W-1:0] max_seen;
  logic [blq_pkg::SUM_W-1:0]    sample_sum;

  // Middle stage.
  logic                         mid_valid;
  logic [blq_pkg::SAMPLE_W-1:0] mid_avg;
  logic                         mid_stable;

  logic in_xfer;
  logic mid_advance;
  logic out_free;

  logic [blq_pkg::INDEX_W-1:0]  base_index;
  logic [blq_pkg::SAMPLE_W-1:0] base_min;
  logic [blq_pkg::SAMPLE_W-1:0] base_max;
  logic [blq_pkg::SUM_W-1:0]    base_sum;
  logic [blq_pkg::SUM_W-1:0]    sum_next;
  logic                         in_stability;
  logic                         last_sample;
  logic [blq_pkg::SAMPLE_W-1:0] spread;

  logic [blq_pkg::PROD_W-1:0]   product;
  logic [blq_pkg::PROD_W-9:0]   scaled;
  logic [blq_pkg::CELL_W-1:0]   cell_next;
  logic                         valid_next;
  blq_pkg::level_t              level_next;

  // Handshake and stage flow control.
  assign cfg_ready   = 1'b1;
  assign out_free    = !out_valid || out_ready;
  assign mid_advance = mid_valid && out_free;
  assign in_ready    = !mid_valid || out_free;
  assign in_xfer     = in_valid && in_ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      divider_ratio_q8 <= blq_pkg::RATIO_RESET;
      spread_limit_mv  <= blq_pkg::SPREAD_RESET;
      floor_mv         <= blq_pkg::FLOOR_RESET;
      low_mv           <= blq_pkg::LOW_RESET;
      critical_mv      <= blq_pkg::CRITICAL_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        blq_pkg::CFG_DIVIDER_RATIO: divider_ratio_q8 <= cfg_data[blq_pkg::RATIO_W-1:0];
        blq_pkg::CFG_SPREAD_LIMIT:  spread_limit_mv  <= cfg_data[blq_pkg::LIMIT_W-1:0];
        blq_pkg::CFG_FLOOR:         floor_mv         <= cfg_data;
        blq_pkg::CFG_LOW:           low_mv           <= cfg_data;
        blq_pkg::CFG_CRITICAL:      critical_mv      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Starting point for this sample: a restart discards the partial measurement.
  always_comb begin
    base_index   = restart ? '0 : sample_index;
    base_min     = restart ? blq_pkg::ADC_MAX : min_seen;
    base_max     = restart ? '0 : max_seen;
    base_sum     = restart ? '0 : sample_sum;
    in_stability = ({1'b0, base_index} < (blq_pkg::INDEX_W + 1)'(blq_pkg::SAMPLES_PER_PHASE));
    last_sample  = (base_index == blq_pkg::INDEX_W'(2 * blq_pkg::SAMPLES_PER_PHASE - 1));
    sum_next     = base_sum + blq_pkg::SUM_W'(sample_mv);
    spread       = (base_max >= base_min) ? (base_max - base_min) : '0;
  end

  // Measurement state update on each sample transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      min_seen     <= blq_pkg::ADC_MAX;
      max_seen     <= '0;
      sample_sum   <= '0;
    end else if (in_xfer) begin
      if (in_stability) begin
        sample_index <= base_index + 1'b1;
        min_seen     <= (sample_mv < base_min) ? sample_mv : base_min;
        max_seen     <= (sample_mv > base_max) ? sample_mv : base_max;
        sample_sum   <= base_sum;
      end else if (!last_sample) begin
        sample_index <= base_index + 1'b1;
        min_seen     <= base_min;
        max_seen     <= base_max;
        sample_sum   <= sum_next;
      end else begin
        sample_index <= '0;
        min_seen     <= blq_pkg::ADC_MAX;
        max_seen     <= '0;
        sample_sum   <= '0;
      end
    end
  end

  // Middle stage: average and stability flag of a finished measurement.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_xfer && !in_stability && last_sample) begin
      mid_valid <= 1'b1;
    end else if (mid_advance) begin
      mid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !in_stability && last_sample) begin
      mid_avg    <= sum_next[blq_pkg::AVG_SHIFT +: blq_pkg::SAMPLE_W];
      mid_stable <= (spread <= blq_pkg::SAMPLE_W'(spread_limit_mv));
    end
  end

  // Scaling to cell millivolts, saturation and level classification.
  always_comb begin
    product    = blq_pkg::PROD_W'(mid_avg) * blq_pkg::PROD_W'(divider_ratio_q8);
    scaled     = product[blq_pkg::PROD_W-1:8];
    cell_next  = (scaled > (blq_pkg::PROD_W - 8)'(blq_pkg::CELL_MAX)) ?
                 blq_pkg::CELL_MAX : scaled[blq_pkg::CELL_W-1:0];
    valid_next = mid_stable && (cell_next >= floor_mv);
    level_next = blq_pkg::LEVEL_NORMAL;
    if (valid_next) begin
      if (cell_next < critical_mv) begin
        level_next = blq_pkg::LEVEL_CRITICAL;
      end else if (cell_next < low_mv) begin
        level_next = blq_pkg::LEVEL_LOW;
      end
    end
  end

  // Output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_advance) begin
      cell_mv   <= cell_next;
      valid_res <= valid_next;
      level     <= level_next;
    end
  end

endmodule

### tb/battery_level_qualifier_tb.sv
// Self-checking testbench for the battery level qualifier: random traffic, prediction and scoring.
`timescale 1ns / 1ps

module battery_level_qualifier_tb;
  import blq_pkg::*;

  localparam int MEAS_LEN      = 2 * SAMPLES_PER_PHASE;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 300;
  localparam int TIMEOUT_NS    = 2_000_000;

  // One sample offered to the block and one expected reading from it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] mv;
    logic                rs;
  } sample_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic              ok;
    level_t            lvl;
  } cell_reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   sample_mv = '0;
  logic                  restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CELL_W-1:0]     cell_mv;
  logic                  valid_res;
  logic [1:0]            level;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Pending samples and readings the block still owes us.
  sample_item_t  sample_q[$];
  cell_reading_t reading_q[$];
  sample_item_t  next_item;
  cell_reading_t want;

  // Local copy of the configuration registers.
  logic [RATIO_W-1:0] cfg_ratio;
  logic [LIMIT_W-1:0] cfg_spread;
  logic [CELL_W-1:0]  cfg_floor;
  logic [CELL_W-1:0]  cfg_low;
  logic [CELL_W-1:0]  cfg_crit;

  // Local copy of the measurement in progress.
  int                  meas_idx;
  logic [SAMPLE_W-1:0] trk_min;
  logic [SAMPLE_W-1:0] trk_max;
  int unsigned         acc_sum;

  // Handshake pacing.
  int in_gap_max = 0;
  int rx_gap_max = 0;
  int in_gap_left;
  int stall_left;
  int rx_draw;
  int hold_left;
  int hold_req = 0;
  int hold_ack;

  // Bookkeeping.
  int n_errors = 0;
  int n_queued = 0;
  int n_samples = 0;
  int n_results = 0;
  int n_qualified = 0;
  int n_low = 0;
  int n_crit = 0;
  int n_sat = 0;
  int n_writes = 0;
  int n_settings = 0;

  battery_level_qualifier uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_mv (sample_mv),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cell_mv   (cell_mv),
    .valid_res (valid_res),
    .level     (level),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop any partial measurement.
  task automatic clear_tracking();
    meas_idx = 0;
    trk_min  = ADC_MAX;
    trk_max  = '0;
    acc_sum  = 0;
  endtask

  // Advance the local measurement by one sample and queue a reading when it completes.
  task automatic qualify_sample(input logic [SAMPLE_W-1:0] mv, input logic rs);
    int unsigned   avg;
    int unsigned   scaled;
    int unsigned   spread;
    cell_reading_t r;
    if (rs) clear_tracking();
    if (meas_idx < SAMPLES_PER_PHASE) begin
      if (mv < trk_min) trk_min = mv;
      if (mv > trk_max) trk_max = mv;
      meas_idx++;
    end else begin
      acc_sum += mv;
      if (meas_idx < MEAS_LEN - 1) begin
        meas_idx++;
      end else begin
        avg    = acc_sum / SAMPLES_PER_PHASE;
        scaled = (avg * cfg_ratio) >> 8;
        if (scaled > CELL_MAX) scaled = CELL_MAX;
        spread = (trk_max >= trk_min) ? trk_max - trk_min : 0;
        r.cell_val = scaled[CELL_W-1:0];
        r.ok       = (spread <= cfg_spread) && (scaled >= cfg_floor);
        r.lvl      = LEVEL_NORMAL;
        // Critical is tested ahead of low, so it wins when both thresholds apply.
        if (r.ok) begin
          if (scaled < cfg_crit) r.lvl = LEVEL_CRITICAL;
          else if (scaled < cfg_low) r.lvl = LEVEL_LOW;
        end
        reading_q.push_back(r);
        clear_tracking();
      end
    end
  endtask

  // Sample driver: predicts on every transfer, then offers the next queued sample after its gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      sample_mv   <= '0;
      restart     <= 1'b0;
      in_gap_left <= 0;
      clear_tracking();
    end else begin
      if (in_valid && in_ready) begin
        qualify_sample(sample_mv, restart);
        n_samples++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap_left != 0) begin
          in_gap_left <= in_gap_left - 1;
          in_valid    <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_item   = sample_q.pop_front();
          sample_mv   <= next_item.mv;
          restart     <= next_item.rs;
          in_valid    <= 1'b1;
          in_gap_left <= $urandom_range(0, in_gap_max);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: scores each transfer and paces out_ready, including the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_ack   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (reading_q.size() == 0) begin
          $display("%0t ns: result with nothing expected: cell_mv=%0d valid_res=%0b level=%0d",
                   $time, cell_mv, valid_res, level);
          n_errors++;
        end else begin
          want = reading_q.pop_front();
          if (cell_mv !== want.cell_val) begin
            $display("%0t ns: cell_mv mismatch: expected %0d, got %0d",
                     $time, want.cell_val, cell_mv);
            n_errors++;
          end
          if (valid_res !== want.ok) begin
            $display("%0t ns: valid_res mismatch: expected %0b, got %0b",
                     $time, want.ok, valid_res);
            n_errors++;
          end
          if (level !== want.lvl) begin
            $display("%0t ns: level mismatch: expected %0d, got %0d", $time, want.lvl, level);
            n_errors++;
          end
          if (want.ok) n_qualified++;
          if (want.lvl == LEVEL_LOW) n_low++;
          if (want.lvl == LEVEL_CRITICAL) n_crit++;
          if (want.cell_val == CELL_MAX) n_sat++;
        end
      end
      if (hold_ack != hold_req) begin
        hold_ack  <= hold_req;
        hold_left <= LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= (hold_left == 1);
      end else if (out_valid && out_ready) begin
        // A draw of zero keeps accepting results back to back.
        rx_draw = $urandom_range(0, rx_gap_max);
        stall_left <= rx_draw;
        out_ready  <= (rx_draw == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One register write; the caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIVIDER_RATIO: cfg_ratio  = data[RATIO_W-1:0];
      CFG_SPREAD_LIMIT:  cfg_spread = data[LIMIT_W-1:0];
      CFG_FLOOR:         cfg_floor  = data;
      CFG_LOW:           cfg_low    = data;
      CFG_CRITICAL:      cfg_crit   = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] ratio,
                               input logic [CFG_DATA_W-1:0] spread,
                               input logic [CFG_DATA_W-1:0] floor_v,
                               input logic [CFG_DATA_W-1:0] low_v,
                               input logic [CFG_DATA_W-1:0] crit_v);
    write_reg(CFG_DIVIDER_RATIO, ratio);
    write_reg(CFG_SPREAD_LIMIT, spread);
    write_reg(CFG_FLOOR, floor_v);
    write_reg(CFG_LOW, low_v);
    write_reg(CFG_CRITICAL, crit_v);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic push_sample(input int mv, input logic rs);
    sample_item_t it;
    it.mv = mv[SAMPLE_W-1:0];
    it.rs = rs;
    sample_q.push_back(it);
    n_queued++;
  endtask

  // A measurement aimed near a threshold or at saturation, with a chosen stability spread.
  // Now and then it is cut short so the next one lands out of step.
  task automatic add_measurement();
    int target;
    int base;
    int spread;
    int lo;
    int hi;
    int cut;
    int hi_pos;
    int mv;
    case ($urandom_range(0, 5))
      0:       target = int'(cfg_crit) + int'($urandom_range(0, 16)) - 8;
      1:       target = int'(cfg_low) + int'($urandom_range(0, 16)) - 8;
      2:       target = int'(cfg_floor) + int'($urandom_range(0, 16)) - 8;
      3:       target = int'(CELL_MAX) + int'($urandom_range(0, 2000));
      default: target = $urandom_range(0, CELL_MAX);
    endcase
    if (target < 0) target = 0;
    if (cfg_ratio == 0) base = $urandom_range(0, ADC_MAX);
    else base = (target * 256 + int'(cfg_ratio) / 2) / int'(cfg_ratio);
    if (base > ADC_MAX) base = ADC_MAX;
    case ($urandom_range(0, 9))
      7, 8:    spread = cfg_spread;
      9:       spread = int'(cfg_spread) + int'($urandom_range(1, 60));
      default: spread = $urandom_range(0, cfg_spread);
    endcase
    lo = base - spread / 2;
    if (lo < 0) lo = 0;
    hi = lo + spread;
    if (hi > ADC_MAX) hi = ADC_MAX;
    cut    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MEAS_LEN - 1) : MEAS_LEN;
    hi_pos = $urandom_range(1, SAMPLES_PER_PHASE - 1);
    for (int k = 0; k < cut; k++) begin
      if (k == 0) mv = lo;
      else if (k == hi_pos) mv = hi;
      else if (k < SAMPLES_PER_PHASE) mv = $urandom_range(lo, hi);
      else mv = base + int'($urandom_range(0, 3));
      if (mv > ADC_MAX) mv = ADC_MAX;
      push_sample(mv, (k == 0) ? ($urandom_range(0, 3) != 0) : 1'b0);
    end
  endtask

  // Queue a mix of measurements and stray samples, then wait for the block to go idle.
  task automatic run_phase(input int n_items, input int in_gap, input int rx_gap);
    int stop_at;
    in_gap_max = in_gap;
    rx_gap_max = rx_gap;
    stop_at    = n_queued + n_items;
    while (n_queued < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5))
          push_sample($urandom_range(0, ADC_MAX), 1'($urandom_range(0, 1)));
      end else begin
        add_measurement();
      end
    end
    do @(negedge clk); while (sample_q.size() != 0 || in_valid || reading_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Main sequence.
  initial begin
    cfg_ratio  = RATIO_RESET;
    cfg_spread = SPREAD_RESET;
    cfg_floor  = FLOOR_RESET;
    cfg_low    = LOW_RESET;
    cfg_crit   = CRITICAL_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a partial measurement at the sample extremes, then a restart into one whose
    // stability window spans the full range while the average saturates the scaled value.
    push_sample(ADC_MAX, 1'b0);
    push_sample(0, 1'b0);
    push_sample(ADC_MAX, 1'b0);
    for (int k = 0; k < MEAS_LEN; k++)
      push_sample((k == 3) ? 0 : ADC_MAX, k == 0);
    push_sample(0, 1'b1);
    run_phase(60, 8, 8);

    // Extremes: ratio data whose upper bits are masked off, widest spread, every threshold at top.
    apply_setting(14'h3800, 14'h3FFF, CELL_MAX, CELL_MAX, CELL_MAX);
    run_phase(60, 0, 0);

    // Unity ratio, zero spread allowed, no floor, critical set above low.
    apply_setting(14'd256, 14'd0, 14'd0, 14'd3000, 14'd3200);
    run_phase(60, 8, 0);

    // Writes past the last register must leave the configuration alone.
    for (int k = int'(CFG_CRITICAL) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(0, 16383)));
    apply_setting(14'd0, 14'd100, 14'd0, 14'd0, 14'd0);
    run_phase(30, 0, 8);

    // Back-pressure: the receiver stops for a long stretch while samples keep coming.
    apply_setting(14'd4095, 14'd10, 14'd1000, 14'd5000, 14'd4000);
    hold_req++;
    run_phase(80, 0, 0);

    // Random settings, with spread data carrying random upper bits.
    repeat (3) begin
      apply_setting(CFG_DATA_W'($urandom_range(0, 16383)),
                    CFG_DATA_W'($urandom_range(0, 16383)),
                    CFG_DATA_W'($urandom_range(0, 4000)),
                    CFG_DATA_W'($urandom_range(2500, 5000)),
                    CFG_DATA_W'($urandom_range(2000, 5000)));
      run_phase(80, $urandom_range(0, 1) * 8, $urandom_range(0, 1) * 8);
    end

    $display("Checked %0d readings from %0d samples: %0d qualified, %0d low, %0d critical,",
             n_results, n_samples, n_qualified, n_low, n_crit);
    $display("%0d saturated; made %0d register writes over %0d settings, stray indexes included.",
             n_sat, n_writes, n_settings);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d samples queued and %0d readings outstanding.",
             sample_q.size(), reading_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
sv/blq_pkg.sv
sv/battery_level_qualifier.sv
tb/battery_level_qualifier_tb.sv
